// ===== hdl/saturating_biquad_filter_core_defines.svh =====
// assertion macros for the saturating biquad filter core
`ifndef SATURATING_BIQUAD_FILTER_CORE_DEFINES_SVH
`define SATURATING_BIQUAD_FILTER_CORE_DEFINES_SVH

// antecedent in this cycle implies consequent in the next cycle
`define SBQ_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("sbq assertion failed");

// antecedent implies consequent in the same cycle
`define SBQ_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("sbq assertion failed");

`endif

// ===== hdl/sbq_pkg.sv =====
// shared types and constants of the saturating biquad filter
`default_nettype none
package sbq_pkg;

	localparam int COEF_FRAC_BITS_DEF = 14;
	localparam int SAMPLE_W = 32;
	localparam int COEF_W = 18;
	localparam int X_W = 17;
	localparam int IDX_W = 3;

	// register indexes, also used as coefficient selects
	localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [IDX_W-1:0] REG_A2 = 3'd4;

	localparam logic signed [COEF_W-1:0] B0_RESET = 18'sd16384;

	localparam logic signed [SAMPLE_W-1:0] X_POS = 32'sd32768;
	localparam logic signed [SAMPLE_W-1:0] X_NEG = -32'sd32768;

	// accumulator operations
	localparam int COMB_W = 3;
	localparam logic [COMB_W-1:0] COMB_NONE  = 3'd0;
	localparam logic [COMB_W-1:0] COMB_Y     = 3'd1;
	localparam logic [COMB_W-1:0] COMB_T     = 3'd2;
	localparam logic [COMB_W-1:0] COMB_U     = 3'd3;
	localparam logic [COMB_W-1:0] COMB_TSUB  = 3'd4;
	localparam logic [COMB_W-1:0] COMB_FINAL = 3'd5;

	typedef struct packed {
		logic              load_x;
		logic [IDX_W-1:0]  coef_sel;
		logic              opnd_y;
		logic [COMB_W-1:0] comb;
		logic              load_out;
	} sbq_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/sbq_datapath.sv =====
// datapath: gain registers, shared multiplier, scaler and saturating accumulators
`default_nettype none
module sbq_datapath
	import sbq_pkg::*;
#(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sbq_cmd_t            cmd,
	input  wire logic [SAMPLE_W-1:0] s_data,
	input  wire logic                cfg_wr_en,
	input  wire logic [IDX_W-1:0]    cfg_index,
	input  wire logic [COEF_W-1:0]   cfg_data,
	output logic [SAMPLE_W-1:0]      m_data
);

	localparam int PROD_W = COEF_W + SAMPLE_W;
	localparam int RND_W = PROD_W + 1;
	localparam logic signed [RND_W-1:0] RND_HALF =
		{{(RND_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
	localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	function automatic logic signed [SAMPLE_W-1:0] sat_add(
		input logic signed [SAMPLE_W:0] v
	);
		if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
			return v[SAMPLE_W] ? S_MIN : S_MAX;
		end
		return v[SAMPLE_W-1:0];
	endfunction

	logic signed [COEF_W-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [X_W-1:0]      x_q;
	logic signed [X_W-1:0]      x_clamp;
	logic signed [SAMPLE_W-1:0] s_sample;
	logic signed [COEF_W-1:0]   coef;
	logic signed [SAMPLE_W-1:0] opnd;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [RND_W-1:0]    rnd_sum;
	logic signed [RND_W-1:0]    shifted;
	logic signed [SAMPLE_W-1:0] scaled;
	logic signed [SAMPLE_W-1:0] gain_s2;
	logic signed [SAMPLE_W-1:0] y_q, t_q, u_q, d1_q, d2_q;
	logic [SAMPLE_W-1:0]        out_q;

	assign s_sample = s_data;

	always_comb begin
		if (s_sample > X_POS) begin
			x_clamp = X_POS[X_W-1:0];
		end else if (s_sample < X_NEG) begin
			x_clamp = X_NEG[X_W-1:0];
		end else begin
			x_clamp = s_sample[X_W-1:0];
		end
	end

	always_comb begin
		case (cmd.coef_sel)
			REG_B0: coef = b0_q;
			REG_B1: coef = b1_q;
			REG_B2: coef = b2_q;
			REG_A1: coef = a1_q;
			REG_A2: coef = a2_q;
			default: coef = b0_q;
		endcase
	end

	assign opnd = cmd.opnd_y ? y_q : {{(SAMPLE_W-X_W){x_q[X_W-1]}}, x_q};

	// round half up, floor shift, then clamp to 32 bits
	assign rnd_sum = {prod_s1[PROD_W-1], prod_s1} + RND_HALF;
	assign shifted = rnd_sum >>> COEF_FRAC_BITS;
	always_comb begin
		if (&shifted[RND_W-1:SAMPLE_W-1] || ~|shifted[RND_W-1:SAMPLE_W-1]) begin
			scaled = shifted[SAMPLE_W-1:0];
		end else begin
			scaled = shifted[RND_W-1] ? S_MIN : S_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= B0_RESET;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_B0: b0_q <= cfg_data;
				REG_B1: b1_q <= cfg_data;
				REG_B2: b2_q <= cfg_data;
				REG_A1: a1_q <= cfg_data;
				REG_A2: a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= x_clamp;
		end
		prod_s1 <= coef * opnd;
		gain_s2 <= scaled;
		case (cmd.comb)
			COMB_Y:    y_q <= sat_add({gain_s2[SAMPLE_W-1], gain_s2} + {d1_q[SAMPLE_W-1], d1_q});
			COMB_T:    t_q <= gain_s2;
			COMB_U:    u_q <= gain_s2;
			COMB_TSUB: t_q <= sat_add({t_q[SAMPLE_W-1], t_q} - {gain_s2[SAMPLE_W-1], gain_s2});
			default: ;
		endcase
		if (cmd.load_out) begin
			out_q <= y_q;
		end
	end

	// delay line update uses the old second delay for the first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (cmd.comb == COMB_FINAL) begin
			d1_q <= sat_add({t_q[SAMPLE_W-1], t_q} + {d2_q[SAMPLE_W-1], d2_q});
			d2_q <= sat_add({u_q[SAMPLE_W-1], u_q} - {gain_s2[SAMPLE_W-1], gain_s2});
		end
	end

	assign m_data = out_q;

endmodule
`default_nettype wire

// ===== hdl/sbq_ctrl.sv =====
// controller: sequences the five products and the stream handshakes
`default_nettype none
module sbq_ctrl
	import sbq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output sbq_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_M0   = 4'd1;
	localparam logic [3:0] ST_M1   = 4'd2;
	localparam logic [3:0] ST_M2   = 4'd3;
	localparam logic [3:0] ST_M3   = 4'd4;
	localparam logic [3:0] ST_M4   = 4'd5;
	localparam logic [3:0] ST_M5   = 4'd6;
	localparam logic [3:0] ST_M6   = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0] state_q, state_d;
	logic       m_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) || ((state_q == ST_OUT) && out_free);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;

	// products are scaled between prod_s1 and gain_s2, then combined
	always_comb begin
		state_d = state_q;
		cmd.load_x = accept;
		cmd.coef_sel = REG_B0;
		cmd.opnd_y = 1'b0;
		cmd.comb = COMB_NONE;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_M0;
			end
			ST_M0: begin
				state_d = ST_M1;
			end
			ST_M1: begin
				cmd.coef_sel = REG_B1;
				state_d = ST_M2;
			end
			ST_M2: begin
				cmd.coef_sel = REG_B2;
				cmd.comb = COMB_Y;
				state_d = ST_M3;
			end
			ST_M3: begin
				cmd.coef_sel = REG_A1;
				cmd.opnd_y = 1'b1;
				cmd.comb = COMB_T;
				state_d = ST_M4;
			end
			ST_M4: begin
				cmd.coef_sel = REG_A2;
				cmd.opnd_y = 1'b1;
				cmd.comb = COMB_U;
				state_d = ST_M5;
			end
			ST_M5: begin
				cmd.comb = COMB_TSUB;
				state_d = ST_M6;
			end
			ST_M6: begin
				cmd.comb = COMB_FINAL;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = s_tvalid ? ST_M0 : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/saturating_biquad_filter_core.sv =====
// top level: biquad section, transposed direct form ii, saturating arithmetic
// a word steps through states M0 to M6; ST_OUT loads its result when the
// output is free and accepts the next word then; one shared 18x32 multiplier
// issues five products through a multiply stage and a round/saturate stage
// the output register holds a result while the next word is taken in
// reset: async; delays cleared, gain_b0 unity, other gains zero, output empty
`default_nettype none
module saturating_biquad_filter_core
	import sbq_pkg::*;
#(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample_in
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [SAMPLE_W-1:0]      m_tdata,   // [31:0] sample_out
	input  wire logic                cfg_wr_en,
	input  wire logic [IDX_W-1:0]    cfg_index,
	input  wire logic [COEF_W-1:0]   cfg_data
);

	sbq_cmd_t cmd;

	sbq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	sbq_datapath #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.s_data    (s_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_data    (m_tdata)
	);

endmodule
`default_nettype wire

// ===== hdl/sbq_checker.sv =====
// port checker for the biquad core and its bind
`default_nettype none
`include "saturating_biquad_filter_core_defines.svh"
module sbq_checker
	import sbq_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [SAMPLE_W-1:0] m_tdata
);

	// a stalled result word stays put
	`SBQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`SBQ_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	// one word in flight: no second word right after an accept
	`SBQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// no result word shows up while a word is still being computed
	`SBQ_ASSERT_NEXT(a_no_early_result, clk, arst_n, !s_tready && !m_tvalid, !m_tvalid)

endmodule

bind saturating_biquad_filter_core sbq_checker u_sbq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
